[hw/rtl/cbor_enc_pkg.sv]
// Package for the CBOR item encoder: the operation codes, the CBOR head constants,
// the descriptor passed from the classifier to the serializer, and the
// shortest-head function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbor_enc_pkg;

    typedef enum logic [3:0] {
        OP_INT     = 4'd0,
        OP_BYTES   = 4'd1,
        OP_TEXT    = 4'd2,
        OP_ARRAY   = 4'd3,
        OP_MAP     = 4'd4,
        OP_FALSE   = 4'd5,
        OP_TRUE    = 4'd6,
        OP_NULL    = 4'd7,
        OP_DOUBLE  = 4'd8,
        OP_PAYLOAD = 4'd9
    } op_t;

    localparam logic [7:0] MAJ_UINT     = 8'h00;
    localparam logic [7:0] MAJ_NINT     = 8'h20;
    localparam logic [7:0] MAJ_BYTES    = 8'h40;
    localparam logic [7:0] MAJ_TEXT     = 8'h60;
    localparam logic [7:0] MAJ_ARRAY    = 8'h80;
    localparam logic [7:0] MAJ_MAP      = 8'hA0;
    localparam logic [7:0] SIMPLE_FALSE = 8'hF4;
    localparam logic [7:0] SIMPLE_TRUE  = 8'hF5;
    localparam logic [7:0] SIMPLE_NULL  = 8'hF6;
    localparam logic [7:0] FLOAT64_HEAD = 8'hFB;
    localparam logic [7:0] IMM_MAX      = 8'h17;
    localparam logic [7:0] ARG1_CODE    = 8'h18;
    localparam logic [7:0] ARG2_CODE    = 8'h19;
    localparam logic [7:0] ARG4_CODE    = 8'h1A;
    localparam logic [7:0] ARG8_CODE    = 8'h1B;

    // Argument byte count after the initial byte: 0, 1, 2, 4 or 8.
    localparam int unsigned ARG_BYTES_MAX = 8;
    localparam int unsigned LEN_W         = 4;

    typedef logic [LEN_W-1:0] len_t;

    // One encoded item: initial byte plus up to eight big-endian argument bytes.
    typedef struct packed {
        logic [7:0]  head;
        logic [63:0] arg;
        len_t        len;
    } desc_t;

    function automatic desc_t cbor_head(input logic [7:0] major, input logic [63:0] val);
        desc_t d;
        d.arg = val;
        if (val <= 64'(IMM_MAX))
        begin
            d.head = major + val[7:0];
            d.len  = len_t'(0);
        end
        else if (val <= 64'h0000_0000_0000_00FF)
        begin
            d.head = major + ARG1_CODE;
            d.len  = len_t'(1);
        end
        else if (val <= 64'h0000_0000_0000_FFFF)
        begin
            d.head = major + ARG2_CODE;
            d.len  = len_t'(2);
        end
        else if (val <= 64'h0000_0000_FFFF_FFFF)
        begin
            d.head = major + ARG4_CODE;
            d.len  = len_t'(4);
        end
        else
        begin
            d.head = major + ARG8_CODE;
            d.len  = len_t'(ARG_BYTES_MAX);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cbor_enc_front.sv]
// Front end of the CBOR item encoder: accepts input transactions and classifies
// each into a head/argument descriptor for the queue. Depends on cbor_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbor_enc_front
    import cbor_enc_pkg::*;
(
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [3:0]         operation,
    input  wire logic signed [31:0] int_value,
    input  wire logic [63:0]        argument,
    input  wire logic               q_full,
    output logic                    q_push,
    output desc_t                   q_desc
);

    logic [31:0] mag;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    // Negative values encode -1 - v, which is the bitwise complement.
    assign mag = int_value[31] ? ~int_value : int_value;

    always_comb
    begin
        q_desc.arg = argument;
        q_desc.len = len_t'(0);
        unique case (operation)
            OP_INT:
            begin
                q_desc = cbor_head(int_value[31] ? MAJ_NINT : MAJ_UINT, {32'd0, mag});
            end
            OP_BYTES:   q_desc = cbor_head(MAJ_BYTES, argument);
            OP_TEXT:    q_desc = cbor_head(MAJ_TEXT, argument);
            OP_ARRAY:   q_desc = cbor_head(MAJ_ARRAY, argument);
            OP_MAP:     q_desc = cbor_head(MAJ_MAP, argument);
            OP_FALSE:   q_desc.head = SIMPLE_FALSE;
            OP_TRUE:    q_desc.head = SIMPLE_TRUE;
            OP_DOUBLE:
            begin
                q_desc.head = FLOAT64_HEAD;
                q_desc.len  = len_t'(ARG_BYTES_MAX);
            end
            OP_PAYLOAD: q_desc.head = argument[7:0];
            default:    q_desc.head = SIMPLE_NULL;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/cbor_enc_queue.sv]
// Short descriptor queue between the classifier and the serializer.
// Depends on cbor_enc_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module cbor_enc_queue
    import cbor_enc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output desc_t      head_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    desc_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cbor_enc_back.sv]
// Back end of the CBOR item encoder: walks the queue head byte by byte,
// initial byte first, then argument bytes big-endian, into an output register.
// Depends on cbor_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbor_enc_back
    import cbor_enc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire desc_t q_desc,
    output logic       q_pop,
    output logic       byte_valid,
    input  wire logic  byte_stall,
    output logic [7:0] out_byte,
    output logic       last
);

    len_t       idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       slot_free;
    logic       emit;
    logic       is_last;
    logic [2:0] pos;
    logic [7:0] cur_byte;

    assign slot_free = !valid_reg || !byte_stall;
    assign emit      = slot_free && q_valid;
    assign is_last   = (idx_reg == q_desc.len);
    assign q_pop     = emit && is_last;

    // Argument byte position from the least significant end.
    assign pos      = 3'(q_desc.len - idx_reg);
    assign cur_byte = (idx_reg == '0) ? q_desc.head : q_desc.arg[{pos, 3'b000} +: 8];

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (slot_free)
        begin
            valid_next = q_valid;
        end
        if (emit)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
        end
    end

    assign byte_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign last       = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg <= q_desc.len))
        else $error("byte index beyond item length");

    a_idx_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> q_valid)
        else $error("partial item without queue entry");

    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == '0))
        else $error("byte index not cleared after last byte");

    a_last_pairs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (valid_reg && (last_reg == $past(q_pop))))
        else $error("last flag does not match item completion");

endmodule

`default_nettype wire

[hw/rtl/cbor_item_encoder_unit.sv]
// Top level of the CBOR item encoder: classifier, descriptor queue and byte
// serializer. Depends on cbor_enc_pkg, cbor_enc_front, cbor_enc_queue, cbor_enc_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// item      in         item_valid / item_stall operation, int_value, argument
// byte      out        byte_valid / byte_stall out_byte, last
//
// Each item yields 1, 2, 3, 5 or 9 bytes; the serializer emits one byte per cycle unless byte_stall holds it.
// An accepted item is written into the descriptor queue; its first byte is then loaded into the byte register.
// The item side stalls only while the descriptor queue (QUEUE_DEPTH entries) is full.
// The byte register reloads when it is empty or its transaction completes, and the queue holds an item.
// Asynchronous active-low reset empties the queue and the output register.

module cbor_item_encoder_unit
    import cbor_enc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [3:0]         operation,
    input  wire logic signed [31:0] int_value,
    input  wire logic [63:0]        argument,
    output logic                    byte_valid,
    input  wire logic               byte_stall,
    output logic [7:0]              out_byte,
    output logic                    last
);

    // Front-to-queue and queue-to-back descriptor paths.
    desc_t push_desc;
    desc_t head_desc;
    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;

    // Classify each accepted transaction into head byte, argument and length.
    cbor_enc_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .int_value  (int_value),
        .argument   (argument),
        .q_full     (full),
        .q_push     (push),
        .q_desc     (push_desc)
    );

    // Hold pending descriptors so the two sides stall independently.
    cbor_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // Serialize the queue head, dropping it as its last byte is registered.
    cbor_enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (head_valid),
        .q_desc     (head_desc),
        .q_pop      (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule

`default_nettype wire
